// ===== hw/rtl/bpg_pkg.sv =====
// Shared constants, types and helpers for the button gesture classifier.
package bpg_pkg;

  localparam int unsigned TimerWidth  = 20;
  localparam int unsigned CfgWidth    = 20;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgWidth-1:0] LongPressReset   = CfgWidth'(750000);
  localparam logic [CfgWidth-1:0] DoublePressReset = CfgWidth'(300000);
  localparam logic [CfgWidth-1:0] DebounceReset    = CfgWidth'(10000);

  localparam longint unsigned TimerMax = (64'd1 << TimerWidth) - 64'd1;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgLongPress   = 2'd0,
    CfgDoublePress = 2'd1,
    CfgDebounce    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    GestSingle = 2'd0,
    GestDouble = 2'd1,
    GestLong   = 2'd2
  } gesture_e;

  typedef struct packed {
    logic [CfgWidth-1:0] long_press_ticks;
    logic [CfgWidth-1:0] double_press_ticks;
    logic [CfgWidth-1:0] debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic func;
    logic button_down;
  } item_t;

  typedef struct packed {
    logic     valid;
    gesture_e gesture;
  } res_t;

  // Saturate a register value into the timer range.
  function automatic logic [TimerWidth-1:0] timer_load(logic [CfgWidth-1:0] v);
    logic [63:0] ve;
    ve = 64'(v);
    if (ve > TimerMax) begin
      return TimerWidth'(TimerMax);
    end
    return TimerWidth'(ve);
  endfunction

endpackage

// ===== hw/rtl/bpg_in_if.sv =====
// Input channel: button edge or tick transactions.
interface bpg_in_if;
  logic valid;
  logic ready;
  logic func;
  logic button_down;

  modport source (output valid, output func, output button_down, input ready);
  modport sink   (input valid, input func, input button_down, output ready);
endinterface

// ===== hw/rtl/bpg_out_if.sv =====
// Output channel: detected gesture transactions.
interface bpg_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] gesture;

  modport source (output valid, output gesture, input ready);
  modport sink   (input valid, input gesture, output ready);
endinterface

// ===== hw/rtl/bpg_core.sv =====
// Gesture state machine: phase, pending gesture, timeout and lockout counters.
module bpg_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  input  bpg_pkg::item_t item_i,
  input  bpg_pkg::cfg_t  cfg_i,
  output bpg_pkg::res_t  res_o
);
  import bpg_pkg::*;

  typedef enum logic [1:0] {
    PhIdle     = 2'd0,
    PhPressed  = 2'd1,
    PhReleased = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    PendNone   = 2'd0,
    PendSingle = 2'd1,
    PendLong   = 2'd2
  } pend_e;

  phase_e                phase_q, phase_d;
  pend_e                 pend_q, pend_d;
  logic [TimerWidth-1:0] timeout_q, timeout_d;
  logic [TimerWidth-1:0] lockout_q, lockout_d;

  always_comb begin
    logic [TimerWidth-1:0] tmo_dec;
    tmo_dec   = timeout_q - TimerWidth'(1);
    phase_d   = phase_q;
    pend_d    = pend_q;
    timeout_d = timeout_q;
    lockout_d = lockout_q;
    res_o     = '{valid: 1'b0, gesture: GestSingle};

    if (item_valid_i) begin
      if (item_i.func) begin
        // tick: count both timers down, report on timeout expiry
        if (lockout_q != '0) begin
          lockout_d = lockout_q - TimerWidth'(1);
        end
        if (timeout_q != '0) begin
          timeout_d = tmo_dec;
          if (tmo_dec == '0 && pend_q != PendNone) begin
            res_o.valid   = 1'b1;
            res_o.gesture = (pend_q == PendLong) ? GestLong : GestSingle;
            pend_d        = PendNone;
            phase_d       = PhIdle;
          end
        end
      end else if (lockout_q == '0) begin
        if (item_i.button_down) begin
          unique case (phase_q)
            PhIdle: begin
              phase_d   = PhPressed;
              pend_d    = PendLong;
              timeout_d = timer_load(cfg_i.long_press_ticks);
              lockout_d = timer_load(cfg_i.debounce_ticks);
            end
            PhReleased: begin
              phase_d       = PhIdle;
              pend_d        = PendNone;
              timeout_d     = '0;
              res_o.valid   = 1'b1;
              res_o.gesture = GestDouble;
            end
            default: ;
          endcase
        end else if (phase_q == PhPressed) begin
          phase_d   = PhReleased;
          pend_d    = PendSingle;
          timeout_d = timer_load(cfg_i.double_press_ticks);
          lockout_d = timer_load(cfg_i.debounce_ticks);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      pend_q    <= PendNone;
      timeout_q <= '0;
      lockout_q <= '0;
    end else begin
      phase_q   <= phase_d;
      pend_q    <= pend_d;
      timeout_q <= timeout_d;
      lockout_q <= lockout_d;
    end
  end

  a_double_from_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.gesture == GestDouble) |-> phase_q == PhReleased)
    else $error("double press reported outside released phase");

  a_report_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> (phase_q == PhIdle && pend_q == PendNone))
    else $error("state not idle after a reported gesture");

  a_lockout_blocks_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && !item_i.func && lockout_q != '0) |=>
      ($stable(phase_q) && $stable(pend_q) && $stable(timeout_q)))
    else $error("edge acted on during lockout");

  a_pending_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> pend_q == PendNone)
    else $error("gesture pending while idle");

endmodule

// ===== hw/rtl/button_press_gesture_classifier_unit.sv =====
// Top level of the push-button single, double and long press classifier.
//
// Usage: drive in_i with one transaction per button edge (func = 0, with
// button_down giving the new level) and one per microsecond tick (func = 1).
// Gestures leave on out_o: 0 single, 1 double, 2 long press. A transaction
// produces zero or one gesture.
// The gesture caused by an input transaction is offered on out_o once that
// transaction has passed the input stage and the core into the output register.
// Throughput: one input transaction per cycle unless out_o stalls; the state
// update is one pass of short logic between input stage and output register.
// Configuration: write cfg_data_i to register cfg_idx_i when cfg_we_i is high
// (0 long press, 1 double press window, 2 debounce, all in ticks). Write only
// while the block is idle. Index 3 is ignored.
// Reset: clears the input stage, the output register and the gesture state,
// and loads 750000, 300000 and 10000 ticks into the three registers.
// Stall: while a gesture waits on out_o the input stage still takes one more
// transaction; after that in_i.ready drops until out_o is drained.
module button_press_gesture_classifier_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bpg_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [bpg_pkg::CfgWidth-1:0]       cfg_data_i,
  bpg_in_if.sink                             in_i,
  bpg_out_if.source                          out_o
);
  import bpg_pkg::*;

  cfg_t   cfg_q;
  logic   stage_valid_q;
  item_t  stage_item_q;
  logic   out_valid_q;
  gesture_e out_gesture_q;
  logic   advance;
  res_t   res;

  // Configuration registers; index 3 means nothing and is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks   <= LongPressReset;
      cfg_q.double_press_ticks <= DoublePressReset;
      cfg_q.debounce_ticks     <= DebounceReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgLongPress:   cfg_q.long_press_ticks   <= cfg_data_i;
        CfgDoublePress: cfg_q.double_press_ticks <= cfg_data_i;
        CfgDebounce:    cfg_q.debounce_ticks     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The staged transaction is processed when the output register can take
  // its result: empty, or being drained this cycle.
  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !stage_valid_q || advance;

  // Input stage: hold the transaction until the core consumes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stage_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      stage_item_q <= '{func: in_i.func, button_down: in_i.button_down};
    end
  end

  bpg_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (stage_valid_q && advance),
    .item_i       (stage_item_q),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  // Output register: load a new gesture, or drop the one just taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_gesture_q <= res.gesture;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.gesture = out_gesture_q;

  a_stage_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid_q && !advance) |=> stage_valid_q)
    else $error("staged transaction lost while output stalled");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |=> out_valid_q)
    else $error("core result not captured in output register");

  a_no_ready_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted with both stages full");

endmodule
